/* sv/rmth_pkg.sv */
package rmth_pkg;

   // operation issued by the controller to the heap datapath
   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_PUSH = 2'd1,
      OP_POP  = 2'd2
   } heap_op_type;

   // command from controller to datapath
   typedef struct packed {
      logic        start;
      heap_op_type op;
      logic        sel_high;   // 1: high (min) heap, 0: low (max) heap
      logic        use_sample; // push value: 1 sample, 0 last popped value
      logic        load_sample;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic busy;
      logic done;
   } status_type;

endpackage

/* sv/rmth_datapath.sv */
module rmth_datapath #(
   parameter int DEPTH      = 513,
   parameter int VALUE_BITS = 32,
   parameter int SIZE_BITS  = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rmth_pkg::cmd_type      cmd,
   input  logic [VALUE_BITS-1:0]  sample_in,
   output rmth_pkg::status_type   status,
   output logic [SIZE_BITS-1:0]   low_size,
   output logic [SIZE_BITS-1:0]   high_size,
   output logic [VALUE_BITS-1:0]  low_top,
   output logic [VALUE_BITS-1:0]  high_top,
   output logic [VALUE_BITS-1:0]  sample_key
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_UP_RD, S_UP_CMP, S_DN_LAST, S_DN_L, S_DN_RC, S_PLACE
   } dp_state_type;

   // two memories, keys biased so unsigned compare is signed order
   logic [VALUE_BITS-1:0] low_mem  [DEPTH];
   logic [VALUE_BITS-1:0] high_mem [DEPTH];

   dp_state_type          state_ff, state_in;
   logic                  sel_ff, sel_in;
   logic [AW:0]           idx_ff, idx_in;      // current hole
   logic [AW:0]           oth_ff, oth_in;      // parent or left child
   logic [AW:0]           n_ff, n_in;          // heap size used during sift-down
   logic [VALUE_BITS-1:0] cur_ff, cur_in;      // value being sifted
   logic [VALUE_BITS-1:0] pop_ff, pop_in;      // last popped top
   logic [VALUE_BITS-1:0] key_ff, key_in;
   logic [VALUE_BITS-1:0] lt_ff, lt_in, ht_ff, ht_in;
   logic [SIZE_BITS-1:0]  ls_ff, ls_in, hs_ff, hs_in;
   logic [VALUE_BITS-1:0] best_ff, best_in;   // left child value
   logic                  done_ff, done_in;

   // sift-down decision
   logic                  decide;
   logic [AW:0]           child_idx;
   logic [VALUE_BITS-1:0] child_val;
   logic [AW:0]           next_left;

   // memory port
   logic                  we;
   logic [AW-1:0]         waddr, raddr;
   logic [VALUE_BITS-1:0] wdata, rdata_low, rdata_high, rdata;
   logic                  wsel;

   always_ff @(posedge clock) begin
      if (we && !wsel) low_mem[waddr] <= wdata;
      if (we && wsel)  high_mem[waddr] <= wdata;
      rdata_low  <= low_mem[raddr];
      rdata_high <= high_mem[raddr];
   end
   assign rdata = sel_ff ? rdata_high : rdata_low;

   function automatic logic above(input logic hi, input logic [VALUE_BITS-1:0] a,
                                  input logic [VALUE_BITS-1:0] b);
      above = hi ? (a < b) : (a > b);
   endfunction

   always_comb begin
      state_in = state_ff; sel_in = sel_ff; idx_in = idx_ff; oth_in = oth_ff;
      n_in = n_ff; cur_in = cur_ff; pop_in = pop_ff; key_in = key_ff;
      lt_in = lt_ff; ht_in = ht_ff; ls_in = ls_ff; hs_in = hs_ff;
      best_in = best_ff; done_in = 1'b0;
      we = 1'b0; wsel = sel_ff; waddr = idx_ff[AW-1:0]; wdata = cur_ff;
      raddr = oth_ff[AW-1:0];
      decide = 1'b0; child_idx = oth_ff; child_val = rdata; next_left = '0;
      if (cmd.load_sample) begin
         key_in = {~sample_in[VALUE_BITS-1], sample_in[VALUE_BITS-2:0]};
      end
      case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               sel_in = cmd.sel_high;
               wsel   = cmd.sel_high;
               case (cmd.op)
                  rmth_pkg::OP_PUSH: begin
                     // open a hole at the end, then sift up
                     cur_in = cmd.use_sample ? key_ff : pop_ff;
                     idx_in = cmd.sel_high ? (AW+1)'(hs_ff) : (AW+1)'(ls_ff);
                     if (cmd.sel_high) hs_in = hs_ff + 1'b1;
                     else              ls_in = ls_ff + 1'b1;
                     if (idx_in == '0) begin
                        we = 1'b1; waddr = '0; wdata = cur_in;
                        done_in = 1'b1;
                     end else begin
                        state_in = S_UP_RD;
                     end
                  end
                  rmth_pkg::OP_POP: begin
                     // take the top, fetch the last entry to sift down
                     pop_in = cmd.sel_high ? ht_ff : lt_ff;
                     n_in = (cmd.sel_high ? (AW+1)'(hs_ff) : (AW+1)'(ls_ff)) - 1'b1;
                     if (cmd.sel_high) hs_in = hs_ff - 1'b1;
                     else              ls_in = ls_ff - 1'b1;
                     idx_in = '0;
                     raddr = n_in[AW-1:0];
                     if (n_in == '0) begin
                        done_in = 1'b1;
                     end else begin
                        state_in = S_DN_LAST;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         // sift up: read parent
         S_UP_RD: begin
            oth_in = (idx_ff - 1'b1) >> 1;
            raddr = oth_in[AW-1:0];
            state_in = S_UP_CMP;
         end
         // sift up: move parent down and climb, or settle
         S_UP_CMP: begin
            if (above(sel_ff, cur_ff, rdata)) begin
               we = 1'b1; waddr = idx_ff[AW-1:0]; wdata = rdata;
               idx_in = oth_ff;
               if (oth_ff == '0) begin
                  state_in = S_PLACE;
               end else begin
                  oth_in = (oth_ff - 1'b1) >> 1;
                  raddr = oth_in[AW-1:0];
               end
            end else begin
               we = 1'b1; waddr = idx_ff[AW-1:0]; wdata = cur_ff;
               state_in = S_IDLE; done_in = 1'b1;
            end
         end
         // sift down: last entry arrives, read left child of root
         S_DN_LAST: begin
            cur_in = rdata;
            if (n_ff > (AW+1)'(1)) begin
               oth_in = (AW+1)'(1);
               raddr = AW'(1);
               state_in = S_DN_L;
            end else begin
               we = 1'b1; waddr = '0; wdata = rdata;
               state_in = S_IDLE; done_in = 1'b1;
            end
         end
         // left child arrives; read right child when present
         S_DN_L: begin
            best_in = rdata;
            if (oth_ff + 1'b1 < n_ff) begin
               raddr = oth_ff[AW-1:0] + 1'b1;
               state_in = S_DN_RC;
            end else begin
               child_idx = oth_ff; child_val = rdata;
               decide = 1'b1;
            end
         end
         // right child arrives; pick the higher ranked child
         S_DN_RC: begin
            if (above(sel_ff, rdata, best_ff)) begin
               child_idx = oth_ff + 1'b1; child_val = rdata;
            end else begin
               child_idx = oth_ff; child_val = best_ff;
            end
            decide = 1'b1;
         end
         // place cur at the hole
         S_PLACE: begin
            we = 1'b1; waddr = idx_ff[AW-1:0]; wdata = cur_ff;
            state_in = S_IDLE; done_in = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase

      // sift down: move the child up and descend, or settle
      if (decide) begin
         next_left = {child_idx[AW-1:0], 1'b1};
         if (above(sel_ff, child_val, cur_ff)) begin
            we = 1'b1; waddr = idx_ff[AW-1:0]; wdata = child_val;
            idx_in = child_idx;
            if (next_left < n_ff) begin
               oth_in = next_left;
               raddr = next_left[AW-1:0];
               state_in = S_DN_L;
            end else begin
               state_in = S_PLACE;
            end
         end else begin
            we = 1'b1; waddr = idx_ff[AW-1:0]; wdata = cur_ff;
            state_in = S_IDLE; done_in = 1'b1;
         end
      end

      // track the top whenever the root is written
      if (we && waddr == '0) begin
         if (wsel) ht_in = wdata;
         else      lt_in = wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ls_ff    <= '0;
         hs_ff    <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ls_ff    <= ls_in;
         hs_ff    <= hs_in;
         done_ff  <= done_in;
      end
      sel_ff <= sel_in; idx_ff <= idx_in; oth_ff <= oth_in; n_ff <= n_in;
      cur_ff <= cur_in; pop_ff <= pop_in; key_ff <= key_in;
      lt_ff <= lt_in; ht_ff <= ht_in; best_ff <= best_in;
   end

   assign status.busy = (state_ff != S_IDLE);
   assign status.done = done_ff;
   assign low_size    = ls_ff;
   assign high_size   = hs_ff;
   assign low_top     = lt_ff;
   assign high_top    = ht_ff;
   assign sample_key  = key_ff;

endmodule

/* sv/rmth_ctrl.sv */
module rmth_ctrl #(
   parameter int CAPACITY   = 1024,
   parameter int VALUE_BITS = 32,
   parameter int SIZE_BITS  = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [31:0]           rsp_median,
   output logic [10:0]           rsp_count,
   output logic                  rsp_dropped,
   output rmth_pkg::cmd_type     cmd,
   input  rmth_pkg::status_type  status,
   input  logic [SIZE_BITS-1:0]  low_size,
   input  logic [SIZE_BITS-1:0]  high_size,
   input  logic [VALUE_BITS-1:0] low_top,
   input  logic [VALUE_BITS-1:0] high_top,
   input  logic [VALUE_BITS-1:0] sample_key
);

   typedef enum logic [3:0] {
      C_IDLE, C_FIRST, C_PICK, C_WAIT1, C_BAL, C_WAIT2, C_BAL2, C_WAIT3,
      C_ORD, C_OWAIT1, C_OWAIT2, C_OWAIT3, C_OWAIT4, C_RESULT
   } ctrl_state_type;

   localparam int CB = SIZE_BITS + 1;

   ctrl_state_type        state_ff;
   logic                  order_ff;
   logic                  rsp_valid_ff;
   logic [31:0]           med_ff;
   logic [10:0]           cnt_ff;
   logic                  drop_ff;
   rmth_pkg::cmd_type     cmd_ff;
   logic [CB-1:0]         total;
   logic [VALUE_BITS-1:0] med_key, med_val;
   logic                  accept;
   logic                  full;

   assign total  = CB'(low_size) + CB'(high_size);
   assign full   = (32'(total) >= 32'(CAPACITY));
   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != C_IDLE) || rsp_valid_ff;
   assign med_key = (high_size > low_size) ? high_top : low_top;
   assign med_val = {~med_key[VALUE_BITS-1], med_key[VALUE_BITS-2:0]};

   function automatic rmth_pkg::cmd_type mk(input rmth_pkg::heap_op_type op,
                                            input logic hi, input logic smp);
      rmth_pkg::cmd_type c;
      c = '0;
      c.start = 1'b1; c.op = op; c.sel_high = hi; c.use_sample = smp;
      mk = c;
   endfunction

   // sequence heap operations per beat, then present the result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= C_IDLE;
         rsp_valid_ff <= 1'b0;
         cmd_ff       <= '0;
         order_ff     <= 1'b0;
      end else begin
         // raise the result, hold it until the beat is taken
         if (state_ff == C_RESULT) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)      rsp_valid_ff <= 1'b0;
         case (state_ff)
            C_IDLE: begin
               cmd_ff <= '0;
               if (accept) state_ff <= C_FIRST;
            end
            C_FIRST: begin
               drop_ff <= full;
               if (full) begin
                  cmd_ff   <= '0;
                  state_ff <= C_RESULT;
               end else if (low_size == '0) begin
                  cmd_ff   <= mk(rmth_pkg::OP_PUSH, 1'b0, 1'b1);
                  order_ff <= (high_size != '0);
                  state_ff <= C_WAIT1;
               end else if (high_size == '0) begin
                  cmd_ff   <= mk(rmth_pkg::OP_PUSH, 1'b1, 1'b1);
                  order_ff <= 1'b1;
                  state_ff <= C_WAIT1;
               end else begin
                  cmd_ff   <= mk(rmth_pkg::OP_PUSH, sample_key > high_top, 1'b1);
                  order_ff <= 1'b0;
                  state_ff <= C_WAIT1;
               end
            end
            C_WAIT1: begin
               cmd_ff <= '0;
               if (status.done) state_ff <= order_ff ? C_ORD : C_BAL;
            end
            C_BAL: begin
               if (CB'(low_size) > CB'(high_size) + 1'b1) begin
                  cmd_ff   <= mk(rmth_pkg::OP_POP, 1'b0, 1'b0);
                  order_ff <= 1'b0;
                  state_ff <= C_WAIT2;
               end else if (CB'(high_size) > CB'(low_size) + 1'b1) begin
                  cmd_ff   <= mk(rmth_pkg::OP_POP, 1'b1, 1'b0);
                  order_ff <= 1'b1;
                  state_ff <= C_WAIT2;
               end else begin
                  cmd_ff   <= '0;
                  state_ff <= C_RESULT;
               end
            end
            C_WAIT2: begin
               if (status.done) begin
                  cmd_ff   <= mk(rmth_pkg::OP_PUSH, !order_ff, 1'b0);
                  state_ff <= C_WAIT3;
               end else begin
                  cmd_ff <= '0;
               end
            end
            C_WAIT3: begin
               cmd_ff <= '0;
               if (status.done) state_ff <= C_RESULT;
            end
            // order tops: pop low, push to high, pop high, push to low
            C_ORD: begin
               if (low_top < high_top) begin
                  cmd_ff   <= '0;
                  state_ff <= C_RESULT;
               end else begin
                  cmd_ff   <= mk(rmth_pkg::OP_POP, 1'b0, 1'b0);
                  state_ff <= C_OWAIT1;
               end
            end
            C_OWAIT1: begin
               if (status.done) begin
                  cmd_ff   <= mk(rmth_pkg::OP_PUSH, 1'b1, 1'b0);
                  state_ff <= C_OWAIT2;
               end else begin
                  cmd_ff <= '0;
               end
            end
            C_OWAIT2: begin
               if (status.done) begin
                  cmd_ff   <= mk(rmth_pkg::OP_POP, 1'b1, 1'b0);
                  state_ff <= C_OWAIT3;
               end else begin
                  cmd_ff <= '0;
               end
            end
            C_OWAIT3: begin
               if (status.done) begin
                  cmd_ff   <= mk(rmth_pkg::OP_PUSH, 1'b0, 1'b0);
                  state_ff <= C_OWAIT4;
               end else begin
                  cmd_ff <= '0;
               end
            end
            C_OWAIT4: begin
               cmd_ff <= '0;
               if (status.done) state_ff <= C_RESULT;
            end
            C_RESULT: begin
               cmd_ff   <= '0;
               med_ff   <= 32'($signed(med_val));
               cnt_ff   <= 11'(total);
               state_ff <= C_IDLE;
            end
            default: begin
               cmd_ff   <= '0;
               state_ff <= C_IDLE;
            end
         endcase
      end
   end

   // capture the sample key at the accepting edge
   always_comb begin
      cmd = cmd_ff;
      cmd.load_sample = accept;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_median  = med_ff;
   assign rsp_count   = cnt_ff;
   assign rsp_dropped = drop_ff;

endmodule

/* sv/running_median_two_heaps.sv */
// Running median over two heaps in memories with one write and one read port.
// A dropped sample needs no heap operation; any other sample needs up to five heap
// operations in the shared datapath, which sifts up and sifts down one level at a time.
// One sample at a time: the next sample is taken only after the result beat is taken.
// Reset: synchronous, active high; clears heap sizes and control, not memories.
module running_median_two_heaps #(
   parameter int CAPACITY   = 1024,
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_median,
   output logic [10:0] rsp_count,
   output logic        rsp_dropped
);

   localparam int DEPTH     = CAPACITY / 2 + 1;
   localparam int SIZE_BITS = $clog2(DEPTH + 1);

   rmth_pkg::cmd_type     cmd;
   rmth_pkg::status_type  status;
   logic [SIZE_BITS-1:0]  low_size, high_size;
   logic [VALUE_BITS-1:0] low_top, high_top, sample_key, sample_ext;

   // sign-extend or truncate sample to value width
   assign sample_ext = VALUE_BITS'($signed(req_sample));

   rmth_ctrl #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS), .SIZE_BITS(SIZE_BITS)) u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .rsp_median, .rsp_count, .rsp_dropped, .cmd, .status,
      .low_size, .high_size, .low_top, .high_top, .sample_key
   );

   rmth_datapath #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS), .SIZE_BITS(SIZE_BITS)) u_dp (
      .clock, .reset, .cmd, .sample_in(sample_ext), .status,
      .low_size, .high_size, .low_top, .high_top, .sample_key
   );

endmodule

/* verif/running_median_two_heaps_tb.sv */
`timescale 1ns / 1ps

module running_median_two_heaps_tb;

   localparam int STORE_CAP   = 1024;
   localparam int HEAP_SLOTS  = STORE_CAP / 2 + 1;
   localparam int RANDOM_BEATS = 1880;
   localparam int STALL_LIMIT = 20000;

   // running median predictor and queue of pending medians
   class median_scoreboard;
      int          heap_val [2][HEAP_SLOTS]; // side 0: low max-heap, side 1: high min-heap
      int unsigned heap_len [2];
      logic [31:0] median_q[$];
      logic [10:0] count_q[$];
      logic        dropped_q[$];
      int          errors;
      int          results_seen;
      int          drops_seen;

      function void clear();
         heap_len[0] = 0;
         heap_len[1] = 0;
         errors = 0;
         results_seen = 0;
         drops_seen = 0;
      endfunction

      function bit ranks_higher(int a, int b, bit side);
         return side ? (a < b) : (a > b);
      endfunction

      function void heap_push(bit side, int v);
         int unsigned i, p;
         int t;
         if (heap_len[side] >= HEAP_SLOTS) return;
         i = heap_len[side];
         heap_val[side][i] = v;
         heap_len[side]++;
         // sift up
         while (i > 0) begin
            p = (i - 1) / 2;
            if (!ranks_higher(heap_val[side][i], heap_val[side][p], side)) break;
            t = heap_val[side][i];
            heap_val[side][i] = heap_val[side][p];
            heap_val[side][p] = t;
            i = p;
         end
      endfunction

      function int heap_pop(bit side);
         int top, t;
         int unsigned n, i, l, r, best;
         if (heap_len[side] == 0) return 0;
         top = heap_val[side][0];
         n = heap_len[side] - 1;
         heap_len[side] = n;
         heap_val[side][0] = heap_val[side][n];
         i = 0;
         // sift down
         forever begin
            l = 2 * i + 1;
            r = l + 1;
            best = i;
            if (l < n && ranks_higher(heap_val[side][l], heap_val[side][best], side)) best = l;
            if (r < n && ranks_higher(heap_val[side][r], heap_val[side][best], side)) best = r;
            if (best == i) break;
            t = heap_val[side][i];
            heap_val[side][i] = heap_val[side][best];
            heap_val[side][best] = t;
            i = best;
         end
         return top;
      endfunction

      function void order_tops();
         int a, b;
         if (heap_len[0] == 0 || heap_len[1] == 0) return;
         if (heap_val[0][0] < heap_val[1][0]) return;
         a = heap_pop(0);
         b = heap_pop(1);
         heap_push(0, b);
         heap_push(1, a);
      endfunction

      // predict the result of one accepted sample
      function void note_sample(logic [31:0] sample);
         int   s;
         logic drop;
         logic [31:0] med;
         s = sample;
         drop = 0;
         if (heap_len[0] + heap_len[1] >= STORE_CAP) begin
            drop = 1;
         end else if (heap_len[0] == 0 && heap_len[1] == 0) begin
            heap_push(0, s);
         end else if (heap_len[0] == 0) begin
            heap_push(0, s);
            order_tops();
         end else if (heap_len[1] == 0) begin
            heap_push(1, s);
            order_tops();
         end else begin
            if (s > heap_val[1][0]) heap_push(1, s);
            else heap_push(0, s);
            if (heap_len[0] > heap_len[1] + 1) heap_push(1, heap_pop(0));
            else if (heap_len[1] > heap_len[0] + 1) heap_push(0, heap_pop(1));
         end
         if (heap_len[1] > heap_len[0]) med = heap_val[1][0];
         else if (heap_len[0] > 0) med = heap_val[0][0];
         else med = '0;
         median_q.insert(median_q.size(), med);
         count_q.insert(count_q.size(), 11'(heap_len[0] + heap_len[1]));
         dropped_q.insert(dropped_q.size(), drop);
      endfunction

      // compare one result beat with the oldest prediction
      function void check_result(logic [31:0] median, logic [10:0] count, logic dropped);
         logic [31:0] m;
         logic [10:0] c;
         logic        d;
         results_seen++;
         if (median_q.size() == 0) begin
            $display("%0t: unexpected result median=%0d count=%0d dropped=%0b",
                     $time, $signed(median), count, dropped);
            errors++;
            return;
         end
         m = median_q.pop_front();
         c = count_q.pop_front();
         d = dropped_q.pop_front();
         if (d) drops_seen++;
         if (median !== m) begin
            $display("%0t: median mismatch expected %0d actual %0d", $time, $signed(m),
                     $signed(median));
            errors++;
         end
         if (count !== c) begin
            $display("%0t: count mismatch expected %0d actual %0d", $time, c, count);
            errors++;
         end
         if (dropped !== d) begin
            $display("%0t: dropped mismatch expected %0b actual %0b", $time, d, dropped);
            errors++;
         end
      endfunction

      function bit drained();
         return median_q.size() == 0;
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [31:0] req_sample = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [31:0] rsp_median;
   logic [10:0] rsp_count;
   logic        rsp_dropped;

   median_scoreboard sb;
   bit  quiet = 0;
   int  idle_cycles = 0;
   int  stall_burst = 0;
   int  beats_in = 0;

   running_median_two_heaps u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_median (rsp_median),
      .rsp_count  (rsp_count),
      .rsp_dropped(rsp_dropped)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // hold off results in random bursts
   always @(posedge clock) begin
      if (stall_burst > 0) begin
         stall_burst <= stall_burst - 1;
         rsp_stall   <= 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_burst <= $urandom_range(0, 3);
         rsp_stall   <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   // check result beats
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_median, rsp_count, rsp_dropped);
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // present one sample and hold it until taken
   task automatic send_sample(input logic [31:0] s);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid  <= 1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
      sb.note_sample(s);
      beats_in++;
   endtask

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(0, 3))
         0: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
         1: return 32'($signed($urandom_range(0, 16)) - 8);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] directed[$];
      sb = new();
      sb.clear();
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // second sample below the first forces the top exchange; equal tops next
      directed = {32'h0000_0005, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'h0000_0000,
                  32'h0000_0001, 32'haaaa_aaaa, 32'h5555_5555, 32'h0000_0005,
                  32'h0000_0005, 32'hffff_fffe, 32'h7fff_fffe, 32'h8000_0001};
      foreach (directed[i]) send_sample(directed[i]);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         // pause once until every pending result has been checked
         if (n == 400) begin
            req_valid <= 0;
            @(posedge clock);
            while (!sb.drained()) @(posedge clock);
         end
         if (n == RANDOM_BEATS - 150) quiet = 1;
         send_sample(pick_sample());
      end
      req_valid <= 0;

      while (!sb.drained()) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("Fed %0d samples, checked %0d results, %0d of them full-store drops.",
               beats_in, sb.results_seen, sb.drops_seen);
      if (sb.errors == 0 && sb.drained())
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* running_median_two_heaps.f */
sv/rmth_pkg.sv
sv/rmth_datapath.sv
sv/rmth_ctrl.sv
sv/running_median_two_heaps.sv
verif/running_median_two_heaps_tb.sv
